// ===== rtl/flkv_pkg.sv =====
// Shared types, codes and CRC helper for the flash log key-value store.
// Used by flkv_ctrl, flkv_dpath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package flkv_pkg;

    // request actions
    localparam logic [1:0] ACT_MOUNT  = 2'd0;
    localparam logic [1:0] ACT_PUT    = 2'd1;
    localparam logic [1:0] ACT_GET    = 2'd2;
    localparam logic [1:0] ACT_DELETE = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NOTFOUND = 2'd1;
    localparam logic [1:0] STS_BADARG   = 2'd2;
    localparam logic [1:0] STS_FULL     = 2'd3;

    // on-flash layout
    localparam logic [7:0]  MAGIC      = 8'h5A;
    localparam logic [7:0]  REC_VALID  = 8'hAA;
    localparam logic [7:0]  REC_DEAD   = 8'h00;
    localparam logic [7:0]  ERASED     = 8'hFF;
    localparam int          HDR_LEN    = 4;
    localparam int          REC_OVH    = 6;
    localparam int          MAX_VAL_BYTES = 8;
    localparam logic [15:0] SEQ_HALF   = 16'h8000;

    // CRC-16-CCITT, MSB first
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic       wr_and;      // program: AND new bits into the byte just read
        logic [7:0] wdata;
        logic       crc_init;
        logic       crc_feed_rd; // feed the registered read byte
        logic       crc_feed_wr; // feed the byte being written
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [15:0] crc;
    } t_dp_stat;

    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/flkv_dpath.sv =====
// Datapath: the flash byte array with its registered read port and the CRC unit.
// Depends on flkv_pkg; driven by flkv_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module flkv_dpath
    import flkv_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
) (
    input  wire logic                              i_clk,
    input  wire t_dp_cmd                           i_cmd,
    input  wire logic [$clog2(2*PAGE_BYTES)-1:0]   i_addr,
    output t_dp_stat                               o_stat
);
    localparam int DEPTH = 2 * PAGE_BYTES;

    logic [7:0]  mem [0:DEPTH-1];
    logic [7:0]  r_rdata;
    logic [15:0] r_crc;

    // write is either an erase fill or a program on top of the byte read just before
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_addr] <= i_cmd.wr_and ? (r_rdata & i_cmd.wdata) : i_cmd.wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_init) begin
            r_crc <= CRC_INIT;
        end else if (i_cmd.crc_feed_rd) begin
            r_crc <= f_crc_byte(r_crc, r_rdata);
        end else if (i_cmd.crc_feed_wr) begin
            r_crc <= f_crc_byte(r_crc, i_cmd.wdata);
        end
    end

    assign o_stat.rdata = r_rdata;
    assign o_stat.crc   = r_crc;

endmodule

`default_nettype wire

// ===== rtl/flkv_ctrl.sv =====
// Controller: request sequencer for mount, put, get, delete and compaction.
// Depends on flkv_pkg; drives flkv_dpath through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module flkv_ctrl
    import flkv_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_action,
    input  wire logic [15:0]                       i_key,
    input  wire logic [63:0]                       i_value,
    input  wire logic [3:0]                        i_value_len,
    input  wire logic [7:0]                        i_capacity,
    output logic                                   o_done,
    output logic [1:0]                             o_status,
    output logic [63:0]                            o_value_out,
    output logic [3:0]                             o_value_len_out,
    output t_dp_cmd                                o_cmd,
    output logic [$clog2(2*PAGE_BYTES)-1:0]        o_addr,
    input  wire t_dp_stat                          i_stat
);
    localparam int AW = $clog2(2 * PAGE_BYTES);
    localparam int OW = $clog2(PAGE_BYTES + 1);
    localparam int SW = OW + 1;
    localparam logic [SW-1:0] PAGE_W    = SW'(PAGE_BYTES);
    localparam logic [OW-1:0] PAGE_LAST = OW'(PAGE_BYTES - 1);
    localparam logic [AW-1:0] MEM_LAST  = AW'(2 * PAGE_BYTES - 1);
    localparam logic [OW-1:0] OFF_HDR   = OW'(HDR_LEN);
    localparam logic [OW-1:0] OFF_OVH   = OW'(REC_OVH);

    typedef enum logic [5:0] {
        ST_CLR, ST_IDLE, ST_FIN,
        ST_MT_RD, ST_MT_CAP, ST_MT_DEC, ST_MT_FMT, ST_MT_FMT2,
        ST_MT_WALK0, ST_MT_WALK, ST_MT_CMPD,
        ST_PUT_CHK, ST_PUT_LAT, ST_PUT_APP, ST_PUT_KILL,
        ST_GET_END, ST_DEL_END,
        ST_LAT_NEXT, ST_LAT_CHK,
        ST_SC_START, ST_SC_RD, ST_SC_CAP, ST_EM_RD, ST_EM_CK,
        ST_AP_START, ST_AP_RD, ST_AP_WR,
        ST_PG_RD, ST_PG_WR,
        ST_ER,
        ST_HD, ST_HD_NX,
        ST_CMP_START, ST_CMP_S1, ST_CMP_S2, ST_CMP_W0, ST_CMP_SCAN,
        ST_CMP_REC, ST_CMP_CPY, ST_CMP_ADV, ST_CMP_ERS, ST_CMP_END
    } t_state;

    t_state r_state;
    t_state r_ret_scan, r_ret_lat, r_ret_app, r_ret_prog, r_ret_er, r_ret_hd, r_ret_cmp;

    // store state
    logic          r_cur;
    logic [OW-1:0] r_wo;
    // request
    logic [15:0]   r_key;
    logic [63:0]   r_val;
    logic [3:0]    r_vlen;
    logic [7:0]    r_cap;
    logic [1:0]    r_status;
    logic [63:0]   r_ov;
    logic [3:0]    r_ol;
    // clearing sweep
    logic [AW-1:0] r_ca;
    // mount header bytes
    logic [2:0]    r_midx;
    logic [47:0]   r_hdr;
    // record scan
    logic          r_spg;
    logic [OW-1:0] r_off;
    logic [3:0]    r_idx;
    logic [7:0]    r_st;
    logic [15:0]   r_k;
    logic [7:0]    r_len;
    logic [63:0]   r_vb;
    logic [7:0]    r_hi;
    logic          r_crcok, r_srec, r_torn, r_need_torn;
    logic [OW-1:0] r_sw;
    // latest-record search
    logic [15:0]   r_lkey;
    logic          r_fnd;
    logic [OW-1:0] r_foff;
    logic [3:0]    r_flen;
    logic [63:0]   r_fval;
    // append
    logic          r_apg;
    logic [OW-1:0] r_aoff;
    logic [15:0]   r_akey;
    logic [3:0]    r_alen;
    logic [63:0]   r_aval;
    logic [3:0]    r_aidx;
    // program and erase
    logic [AW-1:0] r_paddr;
    logic [7:0]    r_pbyte;
    logic          r_epg;
    // header
    logic          r_hpg;
    logic [15:0]   r_hseq;
    logic [1:0]    r_hidx;
    // compaction
    logic [OW-1:0] r_cpos, r_outp;
    logic [15:0]   r_seq;
    logic [15:0]   r_ckey;
    logic [3:0]    r_clen;
    logic [63:0]   r_cval;
    logic [1:0]    r_cst;

    function automatic logic [AW-1:0] f_addr(input logic pg, input logic [OW-1:0] off);
        return pg ? (AW'(PAGE_BYTES) + AW'(off)) : AW'(off);
    endfunction

    logic [7:0]    b;
    logic [3:0]    sc_vi, ap_vi;
    logic          sc_feed;
    logic [7:0]    ap_byte;
    logic [OW-1:0] sc_off;
    logic [OW-1:0] ap_off;
    logic [7:0]    hd_byte;

    assign b      = i_stat.rdata;
    assign sc_vi  = r_idx - 4'd4;
    assign ap_vi  = r_aidx - 4'd3;
    assign sc_off = r_off + OW'(r_idx);
    assign ap_off = r_aoff + OW'(1) + OW'(r_aidx);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        sc_feed = ((r_idx >= 4'd1) && (r_idx <= 4'd3)) ||
                  ((r_idx >= 4'd4) && (r_idx < 4'd4 + r_len[3:0]));
        if (r_aidx == 4'd0) begin
            ap_byte = r_akey[7:0];
        end else if (r_aidx == 4'd1) begin
            ap_byte = r_akey[15:8];
        end else if (r_aidx == 4'd2) begin
            ap_byte = {4'd0, r_alen};
        end else if (r_aidx < 4'd3 + r_alen) begin
            ap_byte = r_aval[8*ap_vi[2:0] +: 8];
        end else if (r_aidx == 4'd3 + r_alen) begin
            ap_byte = i_stat.crc[15:8];
        end else begin
            ap_byte = i_stat.crc[7:0];
        end
        case (r_hidx)
            2'd0:    hd_byte = MAGIC;
            2'd1:    hd_byte = r_hseq[7:0];
            2'd2:    hd_byte = r_hseq[15:8];
            default: hd_byte = ERASED;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd  = '0;
        o_addr = '0;
        case (r_state)
            ST_CLR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wdata = ERASED;
                o_addr      = r_ca;
            end
            ST_MT_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr = (r_midx >= 3'd3) ? f_addr(1'b1, OW'(r_midx - 3'd3))
                                          : f_addr(1'b0, OW'(r_midx));
            end
            ST_SC_START: o_cmd.crc_init = 1'b1;
            ST_SC_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = f_addr(r_spg, sc_off);
            end
            ST_SC_CAP: o_cmd.crc_feed_rd = sc_feed;
            ST_EM_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = f_addr(r_spg, r_sw);
            end
            ST_AP_START: o_cmd.crc_init = 1'b1;
            ST_AP_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = f_addr(r_apg, ap_off);
            end
            ST_AP_WR: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_and      = 1'b1;
                o_cmd.wdata       = ap_byte;
                o_cmd.crc_feed_wr = (r_aidx < 4'd3 + r_alen);
                o_addr            = f_addr(r_apg, ap_off);
            end
            ST_PG_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = r_paddr;
            end
            ST_PG_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_and = 1'b1;
                o_cmd.wdata  = r_pbyte;
                o_addr       = r_paddr;
            end
            ST_ER: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wdata = ERASED;
                o_addr      = f_addr(r_epg, r_sw);
            end
            ST_CMP_START: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = f_addr(r_cur, OW'(1));
            end
            ST_CMP_S1: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = f_addr(r_cur, OW'(2));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_ca       <= '0;
            r_cur      <= 1'b0;
            r_wo       <= '0;
            o_done     <= 1'b0;
            r_ret_scan <= ST_IDLE;
            r_ret_lat  <= ST_IDLE;
            r_ret_app  <= ST_IDLE;
            r_ret_prog <= ST_IDLE;
            r_ret_er   <= ST_IDLE;
            r_ret_hd   <= ST_IDLE;
            r_ret_cmp  <= ST_IDLE;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                ST_CLR: begin
                    if (r_ca == MEM_LAST) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_ca <= r_ca + AW'(1);
                    end
                end

                ST_IDLE: begin
                    if (start) begin
                        r_key    <= i_key;
                        r_val    <= i_value;
                        r_vlen   <= i_value_len;
                        r_cap    <= i_capacity;
                        r_status <= STS_OK;
                        r_ov     <= '0;
                        r_ol     <= '0;
                        r_cst    <= STS_OK;
                        r_lkey   <= i_key;
                        r_off    <= OFF_HDR;
                        r_fnd    <= 1'b0;
                        case (i_action)
                            ACT_MOUNT: begin
                                r_midx  <= '0;
                                r_state <= ST_MT_RD;
                            end
                            ACT_PUT: begin
                                if (i_value_len == 4'd0 ||
                                    i_value_len > 4'(MAX_VAL_BYTES)) begin
                                    r_status <= STS_BADARG;
                                    r_state  <= ST_FIN;
                                end else if (SW'(r_wo) + SW'(REC_OVH) + SW'(i_value_len)
                                             > PAGE_W) begin
                                    r_ret_cmp <= ST_PUT_CHK;
                                    r_state   <= ST_CMP_START;
                                end else begin
                                    r_state <= ST_PUT_LAT;
                                end
                            end
                            ACT_GET: begin
                                r_ret_lat <= ST_GET_END;
                                r_state   <= ST_LAT_NEXT;
                            end
                            default: begin
                                r_ret_lat <= ST_DEL_END;
                                r_state   <= ST_LAT_NEXT;
                            end
                        endcase
                    end
                end

                ST_FIN: begin
                    o_done          <= 1'b1;
                    o_status        <= r_status;
                    o_value_out     <= r_ov;
                    o_value_len_out <= r_ol;
                    r_state         <= ST_IDLE;
                end

                // ---- mount ----
                ST_MT_RD: r_state <= ST_MT_CAP;
                ST_MT_CAP: begin
                    r_hdr <= {b, r_hdr[47:8]};
                    if (r_midx == 3'd5) begin
                        r_state <= ST_MT_DEC;
                    end else begin
                        r_midx  <= r_midx + 3'd1;
                        r_state <= ST_MT_RD;
                    end
                end
                ST_MT_DEC: begin
                    if (r_hdr[7:0] != MAGIC && r_hdr[31:24] != MAGIC) begin
                        r_epg    <= 1'b0;
                        r_sw     <= '0;
                        r_ret_er <= ST_MT_FMT;
                        r_state  <= ST_ER;
                    end else if (r_hdr[7:0] == MAGIC && r_hdr[31:24] == MAGIC) begin
                        // newer by serial compare; equal sequences pick page 1
                        if ((r_hdr[47:32] - r_hdr[23:8]) < SEQ_HALF) begin
                            r_cur <= 1'b1;
                            r_epg <= 1'b0;
                        end else begin
                            r_cur <= 1'b0;
                            r_epg <= 1'b1;
                        end
                        r_sw     <= '0;
                        r_ret_er <= ST_MT_WALK0;
                        r_state  <= ST_ER;
                    end else begin
                        r_cur   <= (r_hdr[7:0] != MAGIC);
                        r_state <= ST_MT_WALK0;
                    end
                end
                ST_MT_FMT: begin
                    r_hpg    <= 1'b0;
                    r_hseq   <= 16'd1;
                    r_hidx   <= '0;
                    r_ret_hd <= ST_MT_FMT2;
                    r_state  <= ST_HD;
                end
                ST_MT_FMT2: begin
                    r_cur   <= 1'b0;
                    r_wo    <= OFF_HDR;
                    r_state <= ST_FIN;
                end
                ST_MT_WALK0: begin
                    r_off       <= OFF_HDR;
                    r_spg       <= r_cur;
                    r_need_torn <= 1'b1;
                    r_ret_scan  <= ST_MT_WALK;
                    r_state     <= ST_SC_START;
                end
                ST_MT_WALK: begin
                    if (r_srec) begin
                        r_off   <= r_off + OFF_OVH + OW'(r_len[3:0]);
                        r_state <= ST_SC_START;
                    end else begin
                        r_wo <= r_off;
                        if (r_torn) begin
                            r_ret_cmp <= ST_MT_CMPD;
                            r_state   <= ST_CMP_START;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_MT_CMPD: begin
                    r_status <= r_cst;
                    r_state  <= ST_FIN;
                end

                // ---- put ----
                ST_PUT_CHK: begin
                    if (r_cst != STS_OK) begin
                        r_status <= r_cst;
                        r_state  <= ST_FIN;
                    end else if (SW'(r_wo) + SW'(REC_OVH) + SW'(r_vlen) > PAGE_W) begin
                        r_status <= STS_FULL;
                        r_state  <= ST_FIN;
                    end else begin
                        r_state <= ST_PUT_LAT;
                    end
                end
                ST_PUT_LAT: begin
                    r_lkey    <= r_key;
                    r_off     <= OFF_HDR;
                    r_fnd     <= 1'b0;
                    r_ret_lat <= ST_PUT_APP;
                    r_state   <= ST_LAT_NEXT;
                end
                ST_PUT_APP: begin
                    r_apg     <= r_cur;
                    r_aoff    <= r_wo;
                    r_akey    <= r_key;
                    r_alen    <= r_vlen;
                    r_aval    <= r_val;
                    r_ret_app <= ST_PUT_KILL;
                    r_state   <= ST_AP_START;
                end
                ST_PUT_KILL: begin
                    r_wo <= r_wo + OFF_OVH + OW'(r_vlen);
                    if (r_fnd) begin
                        r_paddr    <= f_addr(r_cur, r_foff);
                        r_pbyte    <= REC_DEAD;
                        r_ret_prog <= ST_FIN;
                        r_state    <= ST_PG_RD;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end

                // ---- get / delete ----
                ST_GET_END: begin
                    if (!r_fnd) begin
                        r_status <= STS_NOTFOUND;
                    end else if ({4'd0, r_flen} > r_cap) begin
                        r_status <= STS_BADARG;
                    end else begin
                        r_ov <= r_fval;
                        r_ol <= r_flen;
                    end
                    r_state <= ST_FIN;
                end
                ST_DEL_END: begin
                    if (!r_fnd) begin
                        r_status <= STS_NOTFOUND;
                        r_state  <= ST_FIN;
                    end else begin
                        r_paddr    <= f_addr(r_cur, r_foff);
                        r_pbyte    <= REC_DEAD;
                        r_ret_prog <= ST_FIN;
                        r_state    <= ST_PG_RD;
                    end
                end

                // ---- latest valid record of r_lkey from r_off on ----
                ST_LAT_NEXT: begin
                    r_spg       <= r_cur;
                    r_need_torn <= 1'b0;
                    r_ret_scan  <= ST_LAT_CHK;
                    r_state     <= ST_SC_START;
                end
                ST_LAT_CHK: begin
                    if (!r_srec) begin
                        r_state <= r_ret_lat;
                    end else begin
                        if (r_st == REC_VALID && r_k == r_lkey && r_crcok) begin
                            r_fnd  <= 1'b1;
                            r_foff <= r_off;
                            r_flen <= r_len[3:0];
                            r_fval <= r_vb;
                        end
                        r_off   <= r_off + OFF_OVH + OW'(r_len[3:0]);
                        r_state <= ST_SC_START;
                    end
                end

                // ---- scan one record at r_off ----
                ST_SC_START: begin
                    if (SW'(r_off) + SW'(REC_OVH) > PAGE_W) begin
                        r_srec  <= 1'b0;
                        r_torn  <= 1'b0;
                        r_state <= r_ret_scan;
                    end else begin
                        r_idx   <= '0;
                        r_vb    <= '0;
                        r_state <= ST_SC_RD;
                    end
                end
                ST_SC_RD: r_state <= ST_SC_CAP;
                ST_SC_CAP: begin
                    r_idx   <= r_idx + 4'd1;
                    r_state <= ST_SC_RD;
                    if (r_idx == 4'd0) begin
                        r_st <= b;
                    end else if (r_idx == 4'd1) begin
                        r_k[7:0] <= b;
                    end else if (r_idx == 4'd2) begin
                        r_k[15:8] <= b;
                    end else if (r_idx == 4'd3) begin
                        r_len <= b;
                        if (r_st == ERASED) begin
                            if (r_need_torn) begin
                                r_sw    <= r_off;
                                r_state <= ST_EM_RD;
                            end else begin
                                r_srec  <= 1'b0;
                                r_torn  <= 1'b0;
                                r_state <= r_ret_scan;
                            end
                        end else if (b > 8'(MAX_VAL_BYTES) ||
                                     SW'(r_off) + SW'(REC_OVH) + SW'(b[3:0]) > PAGE_W) begin
                            r_srec  <= 1'b0;
                            r_torn  <= 1'b1;
                            r_state <= r_ret_scan;
                        end
                    end else if (r_idx < 4'd4 + r_len[3:0]) begin
                        r_vb[8*sc_vi[2:0] +: 8] <= b;
                    end else if (r_idx == 4'd4 + r_len[3:0]) begin
                        r_hi <= b;
                    end else begin
                        r_crcok <= (i_stat.crc == {r_hi, b});
                        r_srec  <= 1'b1;
                        r_torn  <= 1'b0;
                        r_state <= r_ret_scan;
                    end
                end
                // empty state byte: anything programmed after it means a torn tail
                ST_EM_RD: r_state <= ST_EM_CK;
                ST_EM_CK: begin
                    if (b != ERASED) begin
                        r_srec  <= 1'b0;
                        r_torn  <= 1'b1;
                        r_state <= r_ret_scan;
                    end else if (r_sw == PAGE_LAST) begin
                        r_srec  <= 1'b0;
                        r_torn  <= 1'b0;
                        r_state <= r_ret_scan;
                    end else begin
                        r_sw    <= r_sw + OW'(1);
                        r_state <= ST_EM_RD;
                    end
                end

                // ---- append a record: body, CRC, then state byte ----
                ST_AP_START: begin
                    r_aidx  <= '0;
                    r_state <= ST_AP_RD;
                end
                ST_AP_RD: r_state <= ST_AP_WR;
                ST_AP_WR: begin
                    if (r_aidx == 4'd4 + r_alen) begin
                        r_paddr    <= f_addr(r_apg, r_aoff);
                        r_pbyte    <= REC_VALID;
                        r_ret_prog <= r_ret_app;
                        r_state    <= ST_PG_RD;
                    end else begin
                        r_aidx  <= r_aidx + 4'd1;
                        r_state <= ST_AP_RD;
                    end
                end

                // ---- program one byte ----
                ST_PG_RD: r_state <= ST_PG_WR;
                ST_PG_WR: r_state <= r_ret_prog;

                // ---- erase one page ----
                ST_ER: begin
                    if (r_sw == PAGE_LAST) begin
                        r_state <= r_ret_er;
                    end else begin
                        r_sw <= r_sw + OW'(1);
                    end
                end

                // ---- page header ----
                ST_HD: begin
                    r_paddr    <= f_addr(r_hpg, OW'(r_hidx));
                    r_pbyte    <= hd_byte;
                    r_ret_prog <= ST_HD_NX;
                    r_state    <= ST_PG_RD;
                end
                ST_HD_NX: begin
                    if (r_hidx == 2'd3) begin
                        r_state <= r_ret_hd;
                    end else begin
                        r_hidx  <= r_hidx + 2'd1;
                        r_state <= ST_HD;
                    end
                end

                // ---- compaction into the other page ----
                ST_CMP_START: r_state <= ST_CMP_S1;
                ST_CMP_S1: begin
                    r_seq[7:0] <= b;
                    r_state    <= ST_CMP_S2;
                end
                ST_CMP_S2: begin
                    r_seq[15:8] <= b;
                    r_epg       <= ~r_cur;
                    r_sw        <= '0;
                    r_ret_er    <= ST_CMP_W0;
                    r_state     <= ST_ER;
                end
                ST_CMP_W0: begin
                    r_cpos  <= OFF_HDR;
                    r_outp  <= OFF_HDR;
                    r_state <= ST_CMP_SCAN;
                end
                ST_CMP_SCAN: begin
                    r_off       <= r_cpos;
                    r_spg       <= r_cur;
                    r_need_torn <= 1'b0;
                    r_ret_scan  <= ST_CMP_REC;
                    r_state     <= ST_SC_START;
                end
                ST_CMP_REC: begin
                    if (!r_srec) begin
                        r_hpg    <= ~r_cur;
                        r_hseq   <= r_seq + 16'd1;
                        r_hidx   <= '0;
                        r_ret_hd <= ST_CMP_ERS;
                        r_state  <= ST_HD;
                    end else begin
                        r_ckey <= r_k;
                        r_clen <= r_len[3:0];
                        r_cval <= r_vb;
                        r_cpos <= r_cpos + OFF_OVH + OW'(r_len[3:0]);
                        if (r_st == REC_VALID && r_crcok) begin
                            // latest for its key only if no later good copy exists
                            r_lkey    <= r_k;
                            r_off     <= r_cpos + OFF_OVH + OW'(r_len[3:0]);
                            r_fnd     <= 1'b0;
                            r_ret_lat <= ST_CMP_CPY;
                            r_state   <= ST_LAT_NEXT;
                        end else begin
                            r_state <= ST_CMP_SCAN;
                        end
                    end
                end
                ST_CMP_CPY: begin
                    if (r_fnd) begin
                        r_state <= ST_CMP_SCAN;
                    end else if (SW'(r_outp) + SW'(REC_OVH) + SW'(r_clen) > PAGE_W) begin
                        r_cst   <= STS_FULL;
                        r_state <= r_ret_cmp;
                    end else begin
                        r_apg     <= ~r_cur;
                        r_aoff    <= r_outp;
                        r_akey    <= r_ckey;
                        r_alen    <= r_clen;
                        r_aval    <= r_cval;
                        r_ret_app <= ST_CMP_ADV;
                        r_state   <= ST_AP_START;
                    end
                end
                ST_CMP_ADV: begin
                    r_outp  <= r_outp + OFF_OVH + OW'(r_clen);
                    r_state <= ST_CMP_SCAN;
                end
                ST_CMP_ERS: begin
                    r_epg    <= r_cur;
                    r_sw     <= '0;
                    r_ret_er <= ST_CMP_END;
                    r_state  <= ST_ER;
                end
                ST_CMP_END: begin
                    r_cur   <= ~r_cur;
                    r_wo    <= r_outp;
                    r_cst   <= STS_OK;
                    r_state <= r_ret_cmp;
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/flash_log_key_value_store_core.sv =====
// Top level of the flash log key-value store: controller plus flash datapath.
// Depends on flkv_pkg, flkv_ctrl and flkv_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel: drive i_action, i_key, i_value, i_value_len, i_capacity and
//   raise start; the beat is taken on a rising edge where start is high and busy
//   is low. busy then stays high until the request is finished.
//   Result channel: o_done pulses for exactly one cycle with o_status,
//   o_value_out and o_value_len_out valid in that cycle. Every request gives one
//   result beat. The receiver cannot stall; it must take the beat when o_done is
//   high. busy is already low in the o_done cycle, so the next request beat can
//   be taken at the edge that ends it.
//   Timing: set by the single-port flash array, which moves one byte per cycle
//   during erase; record scans and programming read each byte before they use
//   or program it. A get or delete walks the whole log; a put adds the append
//   of its record. Mount reads both headers, may erase a page and walks the
//   log, and a trailing empty area is checked byte by byte. Compaction erases
//   two pages and rescans the rest of the log once per valid record, so it
//   grows with the square of the record count. Requests run one at a time.
//   Reset: after i_rst_n is released the block sweeps the whole array to 0xFF
//   with busy high, then comes up on page 0, offset 0.
module flash_log_key_value_store_core
    import flkv_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_key,
    input  wire logic [63:0] i_value,
    input  wire logic [3:0]  i_value_len,
    input  wire logic [7:0]  i_capacity,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [63:0]      o_value_out,
    output logic [3:0]       o_value_len_out
);
    localparam int AW = $clog2(2 * PAGE_BYTES);

    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [AW-1:0] dp_addr;

    // sequencer: owns the log pointers and all request control
    flkv_ctrl #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_key           (i_key),
        .i_value         (i_value),
        .i_value_len     (i_value_len),
        .i_capacity      (i_capacity),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_value_out     (o_value_out),
        .o_value_len_out (o_value_len_out),
        .o_cmd           (dp_cmd),
        .o_addr          (dp_addr),
        .i_stat          (dp_stat)
    );

    // flash array and CRC unit
    flkv_dpath #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_cmd  (dp_cmd),
        .i_addr (dp_addr),
        .o_stat (dp_stat)
    );

endmodule

`default_nettype wire

// ===== tb/sv/flash_log_key_value_store_core_checker.sv =====
// Checker for the flash log key-value store: predicts every result from the
// accepted request beats and compares it with the result beat. Uses flkv_pkg.
`timescale 1ns / 1ps

module flash_log_key_value_store_core_checker
    import flkv_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_key,
    input  wire logic [63:0] i_value,
    input  wire logic [3:0]  i_value_len,
    input  wire logic [7:0]  i_capacity,
    input  wire logic        o_done,
    input  wire logic [1:0]  o_status,
    input  wire logic [63:0] o_value_out,
    input  wire logic [3:0]  o_value_len_out,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [3:0]  len;
    } t_reply;

    logic [7:0]  shadow_flash [0:2*PAGE_BYTES-1];
    logic        cur_page;
    int unsigned log_end;
    t_reply      replies_due [$];

    function automatic logic [7:0] peek(logic p, int unsigned off);
        if (off >= PAGE_BYTES) return ERASED;
        return shadow_flash[p*PAGE_BYTES + off];
    endfunction

    function automatic void program_byte(logic p, int unsigned off, logic [7:0] b);
        if (off < PAGE_BYTES) shadow_flash[p*PAGE_BYTES + off] &= b;
    endfunction

    function automatic void erase_page(logic p);
        for (int i = 0; i < PAGE_BYTES; i++) shadow_flash[p*PAGE_BYTES + i] = ERASED;
    endfunction

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        r = c ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        return r;
    endfunction

    function automatic void stamp_header(logic p, logic [15:0] seq);
        program_byte(p, 0, MAGIC);
        program_byte(p, 1, seq[7:0]);
        program_byte(p, 2, seq[15:8]);
        program_byte(p, 3, ERASED);
    endfunction

    // record length at off, 0 at log end or a torn tail
    function automatic int unsigned walk_record(logic p, int unsigned off,
            output logic [7:0] st, output logic [15:0] k, output int unsigned len,
            output logic torn);
        torn = 1'b0;
        st = ERASED;
        k = '0;
        len = 0;
        if (off + REC_OVH > PAGE_BYTES) return 0;
        st = peek(p, off);
        k = {peek(p, off + 2), peek(p, off + 1)};
        len = 32'(peek(p, off + 3));
        if (st == ERASED) begin
            for (int unsigned i = off; i < PAGE_BYTES; i++) begin
                if (peek(p, i) != ERASED) begin
                    torn = 1'b1;
                    break;
                end
            end
            return 0;
        end
        if (len > MAX_VAL_BYTES || off + REC_OVH + len > PAGE_BYTES) begin
            torn = 1'b1;
            return 0;
        end
        return REC_OVH + len;
    endfunction

    function automatic logic crc_matches(logic p, int unsigned off, int unsigned len);
        logic [15:0] c;
        c = CRC_INIT;
        for (int unsigned i = 0; i < 3 + len; i++) c = crc_step(c, peek(p, off + 1 + i));
        return c == {peek(p, off + 4 + len), peek(p, off + 5 + len)};
    endfunction

    function automatic int unsigned newest_match(logic [15:0] key, output int unsigned len_o);
        int unsigned off, found, len, rl;
        logic [7:0]  st;
        logic [15:0] k;
        logic        torn;
        off = HDR_LEN;
        found = 0;
        len_o = 0;
        forever begin
            rl = walk_record(cur_page, off, st, k, len, torn);
            if (rl == 0) break;
            if (st == REC_VALID && k == key && crc_matches(cur_page, off, len)) begin
                found = off;
                len_o = len;
            end
            off += rl;
        end
        return found;
    endfunction

    function automatic void add_record(logic p, int unsigned off, logic [15:0] key,
            logic [63:0] val, int unsigned len);
        logic [15:0] c;
        logic [7:0]  body [0:12];
        body[0] = key[7:0];
        body[1] = key[15:8];
        body[2] = len[7:0];
        for (int unsigned i = 0; i < len; i++) body[3 + i] = val[8*i +: 8];
        c = CRC_INIT;
        for (int unsigned i = 0; i < 3 + len; i++) c = crc_step(c, body[i]);
        body[3 + len] = c[15:8];
        body[4 + len] = c[7:0];
        for (int unsigned i = 0; i < 5 + len; i++) program_byte(p, off + 1 + i, body[i]);
        program_byte(p, off, REC_VALID);
    endfunction

    function automatic logic [1:0] compact_log();
        logic        src, dst, torn;
        int unsigned outp, off, len, rl, ll;
        logic [7:0]  st;
        logic [15:0] k, seq;
        logic [63:0] val;
        src = cur_page;
        dst = ~cur_page;
        seq = {peek(src, 2), peek(src, 1)};
        erase_page(dst);
        outp = HDR_LEN;
        off = HDR_LEN;
        forever begin
            rl = walk_record(src, off, st, k, len, torn);
            if (rl == 0) break;
            if (st == REC_VALID && crc_matches(src, off, len) && newest_match(k, ll) == off) begin
                val = '0;
                for (int unsigned i = 0; i < len; i++) val[8*i +: 8] = peek(src, off + 4 + i);
                if (outp + REC_OVH + len > PAGE_BYTES) return STS_FULL;
                add_record(dst, outp, k, val, len);
                outp += REC_OVH + len;
            end
            off += rl;
        end
        stamp_header(dst, seq + 16'd1);
        erase_page(src);
        cur_page = dst;
        log_end = outp;
        return STS_OK;
    endfunction

    function automatic logic [1:0] mount_store();
        logic        h0, h1, torn;
        logic [15:0] s0, s1, k;
        int unsigned off, len, rl;
        logic [7:0]  st;
        h0 = peek(1'b0, 0) == MAGIC;
        h1 = peek(1'b1, 0) == MAGIC;
        s0 = {peek(1'b0, 2), peek(1'b0, 1)};
        s1 = {peek(1'b1, 2), peek(1'b1, 1)};
        if (!h0 && !h1) begin
            erase_page(1'b0);
            stamp_header(1'b0, 16'd1);
            cur_page = 1'b0;
            log_end = HDR_LEN;
            return STS_OK;
        end
        if (h0 && h1) begin
            cur_page = ((s1 - s0) < SEQ_HALF);
            erase_page(~cur_page);
        end else begin
            cur_page = !h0;
        end
        off = HDR_LEN;
        torn = 1'b0;
        forever begin
            rl = walk_record(cur_page, off, st, k, len, torn);
            if (rl == 0) break;
            off += rl;
        end
        log_end = off;
        if (torn) return compact_log();
        return STS_OK;
    endfunction

    function automatic t_reply predict_reply(logic [1:0] act, logic [15:0] key,
            logic [63:0] val, logic [3:0] vlen, logic [7:0] cap);
        t_reply      r;
        int unsigned old_off, len;
        r = '0;
        case (act)
            ACT_MOUNT: r.status = mount_store();
            ACT_PUT: begin
                if (vlen == 0 || vlen > MAX_VAL_BYTES) begin
                    r.status = STS_BADARG;
                end else begin
                    if (log_end + REC_OVH + vlen > PAGE_BYTES) begin
                        r.status = compact_log();
                        if (r.status == STS_OK && log_end + REC_OVH + vlen > PAGE_BYTES)
                            r.status = STS_FULL;
                    end
                    if (r.status == STS_OK) begin
                        old_off = newest_match(key, len);
                        add_record(cur_page, log_end, key, val, 32'(vlen));
                        log_end += REC_OVH + vlen;
                        if (old_off != 0) program_byte(cur_page, old_off, REC_DEAD);
                    end
                end
            end
            ACT_GET: begin
                old_off = newest_match(key, len);
                if (old_off == 0) begin
                    r.status = STS_NOTFOUND;
                end else if (len > cap) begin
                    r.status = STS_BADARG;
                end else begin
                    for (int unsigned i = 0; i < len; i++)
                        r.value[8*i +: 8] = peek(cur_page, old_off + 4 + i);
                    r.len = len[3:0];
                end
            end
            default: begin
                old_off = newest_match(key, len);
                if (old_off == 0) r.status = STS_NOTFOUND;
                else program_byte(cur_page, old_off, REC_DEAD);
            end
        endcase
        return r;
    endfunction

    initial begin
        for (int i = 0; i < 2*PAGE_BYTES; i++) shadow_flash[i] = ERASED;
        cur_page = 1'b0;
        log_end = 0;
        o_fail_count = 0;
    end

    assign o_pending = replies_due.size();

    always @(posedge i_clk) begin
        t_reply due;
        if (i_rst_n && start && !busy)
            replies_due.push_back(predict_reply(i_action, i_key, i_value, i_value_len,
                                                i_capacity));
        if (i_rst_n && o_done) begin
            if (replies_due.size() == 0) begin
                $error("result beat with no request outstanding");
                o_fail_count <= o_fail_count + 1;
            end else begin
                due = replies_due.pop_front();
                if (o_status !== due.status || o_value_out !== due.value ||
                    o_value_len_out !== due.len) begin
                    if (o_status !== due.status)
                        $error("status: expected %0d, got %0d", due.status, o_status);
                    if (o_value_out !== due.value)
                        $error("value_out: expected %h, got %h", due.value, o_value_out);
                    if (o_value_len_out !== due.len)
                        $error("value_len_out: expected %0d, got %0d", due.len,
                               o_value_len_out);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end

endmodule

// ===== tb/sv/flash_log_key_value_store_core_test.sv =====
// Top of the key-value store testbench: clock, reset, request stimulus and verdict.
// Depends on flkv_pkg, the block and flash_log_key_value_store_core_checker.
`timescale 1ns / 1ps

module flash_log_key_value_store_core_test
    import flkv_pkg::*;
;

    localparam int PAGE_BYTES = 1024;
    // cycles without an accepted beat before giving up; covers a full-page compaction
    localparam int STALL_LIMIT = 1_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [15:0] i_key;
    logic [63:0] i_value;
    logic [3:0]  i_value_len;
    logic [7:0]  i_capacity;
    logic        o_done;
    logic [1:0]  o_status;
    logic [63:0] o_value_out;
    logic [3:0]  o_value_len_out;

    int          fail_count;
    int          pending;
    int          quiet_cycles;
    logic        gaps_on;
    logic [15:0] key_pool [0:5];

    flash_log_key_value_store_core #(.PAGE_BYTES(PAGE_BYTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_key(i_key), .i_value(i_value),
        .i_value_len(i_value_len), .i_capacity(i_capacity),
        .o_done(o_done), .o_status(o_status), .o_value_out(o_value_out),
        .o_value_len_out(o_value_len_out)
    );

    flash_log_key_value_store_core_checker #(.PAGE_BYTES(PAGE_BYTES)) scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_key(i_key), .i_value(i_value),
        .i_value_len(i_value_len), .i_capacity(i_capacity),
        .o_done(o_done), .o_status(o_status), .o_value_out(o_value_out),
        .o_value_len_out(o_value_len_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Drop any run that stops accepting requests.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Send one request beat; hold it until busy is seen low at an edge.
    // An idle gap lowers start first, so start never gets two updates in one step.
    task automatic send_request(logic [1:0] act, logic [15:0] key, logic [63:0] val,
                                logic [3:0] vlen, logic [7:0] cap);
        if (gaps_on && $urandom_range(99) < 38) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_key       <= key;
        i_value     <= val;
        i_value_len <= vlen;
        i_capacity  <= cap;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Random request: mostly puts and gets on a small key set so records die and
    // get compacted, with rare mounts and some keys from the whole range.
    task automatic send_random();
        int unsigned pick;
        logic [1:0]  act;
        logic [15:0] key;
        logic [3:0]  vlen;
        logic [7:0]  cap;
        pick = $urandom_range(99);
        if (pick < 4)       act = ACT_MOUNT;
        else if (pick < 50) act = ACT_PUT;
        else if (pick < 80) act = ACT_GET;
        else                act = ACT_DELETE;
        key  = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                        : key_pool[$urandom_range(5)];
        vlen = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
        cap  = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                        : 8'($urandom_range(8, 255));
        send_request(act, key, rand_word(), vlen, cap);
    endtask

    initial begin
        start       <= 1'b0;
        i_rst_n     <= 1'b0;
        i_action    <= ACT_MOUNT;
        i_key       <= '0;
        i_value     <= '0;
        i_value_len <= '0;
        i_capacity  <= '0;
        gaps_on = 1'b1;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 6; i++) key_pool[i] = 16'($urandom_range(16'hFFFF));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // requests before any mount act on page 0, with the write offset at 0
        send_request(ACT_GET,    16'h1234, '0, 4'd0, 8'd255);
        send_request(ACT_DELETE, 16'h1234, '0, 4'd0, 8'd0);
        send_request(ACT_PUT,    16'hFFFF, '1, 4'd8, 8'd0);
        send_request(ACT_GET,    16'hFFFF, '0, 4'd0, 8'd255);
        // format a blank store, then mount the formatted one
        send_request(ACT_MOUNT,  16'h0000, '0, 4'd0, 8'd0);
        send_request(ACT_MOUNT,  16'hFFFF, '1, 4'hF, 8'hFF);
        // bad lengths
        send_request(ACT_PUT,    16'h0001, '1, 4'd0, 8'd0);
        send_request(ACT_PUT,    16'h0001, '1, 4'd9, 8'd0);
        send_request(ACT_PUT,    16'h0001, '1, 4'd15, 8'd0);
        // field extremes
        send_request(ACT_PUT,    16'h0000, 64'h0123_4567_89AB_CDEF, 4'd1, 8'd0);
        send_request(ACT_PUT,    16'hFFFF, '1, 4'd8, 8'd0);
        send_request(ACT_GET,    16'hFFFF, '0, 4'd0, 8'd0);
        send_request(ACT_GET,    16'hFFFF, '0, 4'd0, 8'd7);
        send_request(ACT_GET,    16'hFFFF, '0, 4'd0, 8'd8);
        send_request(ACT_GET,    16'h0000, '0, 4'd0, 8'd255);
        send_request(ACT_GET,    16'h5555, '0, 4'd0, 8'd255);
        // overwrite kills the old record
        send_request(ACT_PUT,    16'h0000, 64'hFEDC_BA98_7654_3210, 4'd5, 8'd0);
        send_request(ACT_GET,    16'h0000, '0, 4'd0, 8'd5);
        // delete, then miss on get and delete
        send_request(ACT_DELETE, 16'h0000, '0, 4'd0, 8'd0);
        send_request(ACT_GET,    16'h0000, '0, 4'd0, 8'd255);
        send_request(ACT_DELETE, 16'h0000, '0, 4'd0, 8'd0);
        send_request(ACT_MOUNT,  16'h0000, '0, 4'd0, 8'd0);

        for (int n = 0; n < 100; n++) begin
            gaps_on = !(n >= 40 && n < 75);
            send_random();
        end
        // fill the page with distinct keys until compaction cannot make room
        for (int n = 0; n < 68; n++)
            send_request(ACT_PUT, 16'(16'h7000 + n), rand_word(), 4'd8, 8'd0);
        send_request(ACT_MOUNT, 16'h0000, '0, 4'd0, 8'd0);
        for (int n = 0; n < 68; n++)
            send_request(ACT_DELETE, 16'(16'h7000 + n), '0, 4'd0, 8'd0);
        for (int n = 0; n < 40; n++) send_random();
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/flkv_pkg.sv
rtl/flkv_dpath.sv
rtl/flkv_ctrl.sv
rtl/flash_log_key_value_store_core.sv
tb/sv/flash_log_key_value_store_core_checker.sv
tb/sv/flash_log_key_value_store_core_test.sv
